@@ hdl/srdd_pkg.sv @@
// Shared types and constants for the sensor record delta decoder.
// No dependencies; imported by every file of the block but the two interfaces.
`default_nettype none

package srdd_pkg;

  localparam int unsigned SENSOR_SLOTS_DEF = 16;
  localparam int unsigned FIFO_DEPTH_DEF   = 4;
  localparam int unsigned IDX_W            = 5;
  localparam int unsigned VAL_W            = 32;
  localparam int unsigned LEN_W            = 7;
  localparam int unsigned CODE_W           = 16;
  localparam logic [CODE_W-1:0] MISSING_RST = 16'h8000;
  localparam logic [2:0] VARINT_MAX        = 3'd5;
  localparam logic [LEN_W-1:0] MASK_BYTES  = 7'd3;
  localparam logic [LEN_W-1:0] EPOCH_BYTES = 7'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LONG  = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  // one command per byte that produces results
  typedef struct packed {
    logic             val_en;
    logic [IDX_W-1:0] val_idx;
    logic [VAL_W-1:0] val_data;
    logic             val_pres;
    logic             abs_en;
    logic [IDX_W-1:0] abs_lo;
    logic [IDX_W-1:0] abs_hi;
    logic             err_en;
    logic             rec_end;
    status_e          status;
    logic [LEN_W-1:0] rec_len;
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/srdd_in_if.sv @@
// Input byte channel: valid/ready plus one stream byte and its flags.
// Depends on nothing.
`default_nettype none

interface srdd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       anchor;
  logic       end_of_buffer;

  modport source (output valid, data_byte, anchor, end_of_buffer, input ready);
  modport sink (input valid, data_byte, anchor, end_of_buffer, output ready);
endinterface

`default_nettype wire

@@ hdl/srdd_out_if.sv @@
// Result channel: valid/ready plus one decoded field or status beat.
// Depends on nothing.
`default_nettype none

interface srdd_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_index;
  logic [31:0] field_value;
  logic        present;
  logic [1:0]  status;
  logic [6:0]  record_length;
  logic        record_end;

  modport source (output valid, field_index, field_value, present, status, record_length,
                  record_end, input ready);
  modport sink (input valid, field_index, field_value, present, status, record_length,
                record_end, output ready);
endinterface

`default_nettype wire

@@ hdl/sensor_record_delta_decoder_top.sv @@
// Top level of the sensor record delta decoder: parser, command queue, sequencer.
// Depends on srdd_pkg, srdd_in_if, srdd_out_if, srdd_front, srdd_cmd_fifo, srdd_back.
//
//   port        dir  beat
//   byte_i      in   data_byte, anchor, end_of_buffer
//   result_o    out  field_index, field_value, present, status, record_length, record_end
//   cfg_*_i     in   missing_value_code write, no handshake
//
// One byte per cycle enters; the parser finishes its work in that cycle.
// Results leave one per cycle while result_o is ready; a byte followed by a run of absent fields
// gives one beat per field, and a 4-deep command queue absorbs the burst.
// byte_i stalls only when that queue is full. Async active-low reset; no
// clearing pass, the block takes bytes in the first cycle after reset.
`default_nettype none

module sensor_record_delta_decoder_top
  import srdd_pkg::*;
#(
  parameter int unsigned SENSOR_SLOTS = SENSOR_SLOTS_DEF,
  parameter int unsigned FIFO_DEPTH   = FIFO_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  srdd_in_if.sink                byte_i,
  srdd_out_if.source             result_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CODE_W-1:0] cfg_data_i
);

  logic [CODE_W-1:0] missing_q;
  logic              push, full, pop, head_valid;
  cmd_t              cmd, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      missing_q <= MISSING_RST;
    end else if (cfg_we_i) begin
      missing_q <= cfg_data_i;
    end
  end

  srdd_front #(
    .SENSOR_SLOTS(SENSOR_SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_ready_o (byte_i.ready),
    .data_byte_i(byte_i.data_byte),
    .anchor_i   (byte_i.anchor),
    .eob_i      (byte_i.end_of_buffer),
    .missing_i  (missing_q),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  srdd_cmd_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (cmd),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  srdd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .missing_i   (missing_q),
    .res_o       (result_o)
  );

endmodule

`default_nettype wire

@@ hdl/srdd_front.sv @@
// Front end: parses one byte per cycle while the command queue has room, keeps record state and commits values.
// Depends on srdd_pkg; feeds commands to srdd_cmd_fifo.
`default_nettype none

module srdd_front
  import srdd_pkg::*;
#(
  parameter int unsigned SENSOR_SLOTS = SENSOR_SLOTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              anchor_i,
  input  wire logic              eob_i,
  input  wire logic [CODE_W-1:0] missing_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output cmd_t                   cmd_o
);

  localparam int unsigned NF = 2 + SENSOR_SLOTS;
  localparam int unsigned FW = (NF > 1) ? $clog2(NF) : 1;
  localparam logic [IDX_W-1:0] NF_IDX = IDX_W'(NF);

  logic             acc;
  logic             anchor_q, anchor_d, is_anc;
  logic [LEN_W-1:0] rbc_q, rbc_d, rbc_n, off;
  logic [31:0]      acc_q, acc_d, vsh, unew, dlt;
  logic [2:0]       vcnt_q, vcnt_d, vcnt_n;
  logic [IDX_W-1:0] cf_q, cf_d, f5, nxt, jsel;
  logic [NF-1:0]    mask_q, mask_d;
  logic [23:0]      mask24;
  logic [31:0]      pend_epoch_q, pend_epoch_d, last_epoch_q, last_epoch_d;
  logic [15:0]      last_val_q [NF];
  logic [15:0]      last_val_d [NF];
  logic [NF-1:0]    valid_q, valid_d;
  logic [15:0]      pend_q [NF];
  logic [15:0]      pend_m [NF];
  logic             wr_en;
  logic [FW-1:0]    wr_idx, fi;
  logic [15:0]      wr_val, v;
  logic             done, verr, found, commit_anc, commit_dlt;
  cmd_t             cmd;

  assign in_ready_o = ~full_i;
  assign acc        = in_valid_i & ~full_i;
  assign is_anc     = (rbc_q == '0) ? anchor_i : anchor_q;
  assign rbc_n      = rbc_q + 7'd1;
  assign off        = rbc_n - 7'd5;

  always_comb begin
    unique case (vcnt_q)
      3'd0:    vsh = {25'b0, data_byte_i[6:0]};
      3'd1:    vsh = {18'b0, data_byte_i[6:0], 7'b0};
      3'd2:    vsh = {11'b0, data_byte_i[6:0], 14'b0};
      3'd3:    vsh = {4'b0, data_byte_i[6:0], 21'b0};
      3'd4:    vsh = {data_byte_i[3:0], 28'b0};
      default: vsh = 32'b0;
    endcase
  end

  assign unew   = acc_q | vsh;
  assign vcnt_n = vcnt_q + 3'd1;
  assign dlt    = (unew >> 1) ^ {32{unew[0]}};
  assign nxt    = cf_q + 5'd1;

  always_comb begin
    found = 1'b0;
    jsel  = NF_IDX + 5'd1;
    for (int k = 1; k <= NF; k++) begin
      if (!found && IDX_W'(k) >= nxt && mask_q[k-1]) begin
        found = 1'b1;
        jsel  = IDX_W'(k);
      end
    end
  end

  always_comb begin
    anchor_d     = is_anc;
    rbc_d        = rbc_n;
    acc_d        = acc_q;
    vcnt_d       = vcnt_q;
    cf_d         = cf_q;
    mask_d       = mask_q;
    mask24       = 24'(mask_q);
    pend_epoch_d = pend_epoch_q;
    wr_en        = 1'b0;
    wr_idx       = '0;
    wr_val       = '0;
    v            = '0;
    f5           = '0;
    fi           = '0;
    done         = 1'b0;
    verr         = 1'b0;
    commit_anc   = 1'b0;
    commit_dlt   = 1'b0;
    cmd          = '0;
    cmd.status   = ST_OK;
    if (is_anc) begin
      if (rbc_n <= EPOCH_BYTES) begin
        acc_d = acc_q | (32'(data_byte_i) << {rbc_n[1:0] - 2'd1, 3'b000});
        if (rbc_n == EPOCH_BYTES) begin
          pend_epoch_d = acc_d;
          acc_d        = '0;
          cmd.val_en   = 1'b1;
          cmd.val_idx  = '0;
          cmd.val_data = pend_epoch_d;
          cmd.val_pres = 1'b1;
        end
      end else if (!off[0]) begin
        acc_d = 32'(data_byte_i);
      end else begin
        f5           = off[5:1];
        v            = {data_byte_i, acc_q[7:0]};
        acc_d        = '0;
        wr_en        = 1'b1;
        wr_idx       = f5[FW-1:0];
        wr_val       = v;
        cmd.val_en   = 1'b1;
        cmd.val_idx  = f5 + 5'd1;
        cmd.val_data = {16'b0, v};
        cmd.val_pres = (v != missing_i);
        if (f5 == NF_IDX - 5'd1) begin
          commit_anc = 1'b1;
          done       = 1'b1;
        end
      end
    end else if (rbc_n <= MASK_BYTES) begin
      mask24 = 24'(mask_q) | (24'(data_byte_i) << {rbc_n[1:0] - 2'd1, 3'b000});
      mask_d = mask24[NF-1:0];
      if (rbc_n == MASK_BYTES) begin
        cf_d   = '0;
        acc_d  = '0;
        vcnt_d = '0;
      end
    end else if (data_byte_i[7]) begin
      if (vcnt_n >= VARINT_MAX) begin
        verr = 1'b1;
      end else begin
        acc_d  = unew;
        vcnt_d = vcnt_n;
      end
    end else begin
      acc_d        = '0;
      vcnt_d       = '0;
      cmd.val_en   = 1'b1;
      cmd.val_idx  = cf_q;
      cmd.val_pres = 1'b1;
      if (cf_q == '0) begin
        pend_epoch_d = last_epoch_q + dlt;
        cmd.val_data = pend_epoch_d;
      end else begin
        f5           = cf_q - 5'd1;
        fi           = f5[FW-1:0];
        v            = valid_q[fi] ? last_val_q[fi] + dlt[15:0] : dlt[15:0];
        wr_en        = 1'b1;
        wr_idx       = fi;
        wr_val       = v;
        cmd.val_data = {16'b0, v};
      end
      if (jsel > nxt) begin
        cmd.abs_en = 1'b1;
        cmd.abs_lo = nxt;
        cmd.abs_hi = jsel - 5'd1;
      end
      cf_d = jsel;
      if (jsel == NF_IDX + 5'd1) begin
        commit_dlt = 1'b1;
        done       = 1'b1;
      end
    end

    if (done) begin
      cmd.rec_end = 1'b1;
      cmd.rec_len = rbc_n;
    end else if (verr || eob_i) begin
      cmd.val_en  = verr ? 1'b0 : cmd.val_en;
      cmd.abs_en  = verr ? 1'b0 : cmd.abs_en;
      cmd.err_en  = 1'b1;
      cmd.status  = verr ? ST_LONG : ST_TRUNC;
      cmd.rec_len = rbc_n;
    end

    if (done || verr || eob_i) begin
      anchor_d = 1'b0;
      rbc_d    = '0;
      acc_d    = '0;
      vcnt_d   = '0;
      cf_d     = '0;
      mask_d   = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < NF; i++) begin
      pend_m[i] = (wr_en && wr_idx == FW'(i)) ? wr_val : pend_q[i];
    end
    last_epoch_d = last_epoch_q;
    valid_d      = valid_q;
    for (int i = 0; i < NF; i++) begin
      last_val_d[i] = last_val_q[i];
      if (commit_anc) begin
        last_val_d[i] = pend_m[i];
        valid_d[i]    = (pend_m[i] != missing_i);
      end else if (commit_dlt && mask_q[i]) begin
        last_val_d[i] = pend_m[i];
        valid_d[i]    = 1'b1;
      end
    end
    if (commit_anc || commit_dlt) begin
      last_epoch_d = pend_epoch_d;
    end
  end

  assign push_o = acc & (cmd.val_en | cmd.abs_en | cmd.err_en);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q     <= 1'b0;
      rbc_q        <= '0;
      acc_q        <= '0;
      vcnt_q       <= '0;
      cf_q         <= '0;
      mask_q       <= '0;
      pend_epoch_q <= '0;
      last_epoch_q <= '0;
      valid_q      <= '0;
      for (int i = 0; i < NF; i++) begin
        last_val_q[i] <= '0;
      end
    end else if (acc) begin
      anchor_q     <= anchor_d;
      rbc_q        <= rbc_d;
      acc_q        <= acc_d;
      vcnt_q       <= vcnt_d;
      cf_q         <= cf_d;
      mask_q       <= mask_d;
      pend_epoch_q <= pend_epoch_d;
      last_epoch_q <= last_epoch_d;
      valid_q      <= valid_d;
      for (int i = 0; i < NF; i++) begin
        last_val_q[i] <= last_val_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && wr_en) begin
      pend_q[wr_idx] <= wr_val;
    end
  end

endmodule

`default_nettype wire

@@ hdl/srdd_cmd_fifo.sv @@
// Small command queue between the byte parser and the result sequencer.
// Depends on srdd_pkg.
`default_nettype none

module srdd_cmd_fifo
  import srdd_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output cmd_t      head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o       = (cnt_q == CW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rp_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/srdd_back.sv @@
// Back end: expands each command into result beats, one per cycle unless the
// sink stalls, into an output register. Depends on srdd_pkg and srdd_out_if.
`default_nettype none

module srdd_back
  import srdd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  cmd_t                   head_i,
  output logic                   pop_o,
  input  wire logic [CODE_W-1:0] missing_i,
  srdd_out_if.source             res_o
);

  localparam logic [1:0] PH_VAL = 2'd0;
  localparam logic [1:0] PH_ABS = 2'd1;
  localparam logic [1:0] PH_ERR = 2'd2;

  logic [1:0]       ph_q, ph_d;
  logic [IDX_W-1:0] cnt_q, cnt_d, aidx;
  logic             sel_val, sel_abs, last, emit, rend;
  logic             ov_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             pres_q, pres_d, end_q;
  logic [1:0]       st_q, st_d;
  logic [LEN_W-1:0] len_q, len_d;

  assign sel_val = (ph_q == PH_VAL) && head_i.val_en;
  assign sel_abs = !sel_val && (ph_q != PH_ERR) && head_i.abs_en;
  assign aidx    = (ph_q == PH_ABS) ? cnt_q : head_i.abs_lo;
  assign emit    = head_valid_i && (!ov_q || res_o.ready);
  assign pop_o   = emit && last;
  assign rend    = last && (head_i.rec_end || head_i.err_en);

  always_comb begin
    if (sel_val) begin
      last  = !head_i.abs_en && !head_i.err_en;
      idx_d = head_i.val_idx;
      val_d = head_i.val_data;
      pres_d = head_i.val_pres;
    end else if (sel_abs) begin
      last  = (aidx == head_i.abs_hi) && !head_i.err_en;
      idx_d = aidx;
      val_d = {16'b0, missing_i};
      pres_d = 1'b0;
    end else begin
      last  = 1'b1;
      idx_d = '0;
      val_d = '0;
      pres_d = 1'b0;
    end
    st_d  = rend ? head_i.status : ST_OK;
    len_d = rend ? head_i.rec_len : '0;
  end

  always_comb begin
    ph_d  = ph_q;
    cnt_d = cnt_q;
    if (emit) begin
      if (last) begin
        ph_d = PH_VAL;
      end else if (sel_val) begin
        ph_d  = head_i.abs_en ? PH_ABS : PH_ERR;
        cnt_d = head_i.abs_lo;
      end else if (aidx == head_i.abs_hi) begin
        ph_d = PH_ERR;
      end else begin
        ph_d  = PH_ABS;
        cnt_d = aidx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_VAL;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      idx_q  <= idx_d;
      val_q  <= val_d;
      pres_q <= pres_d;
      st_q   <= st_d;
      len_q  <= len_d;
      end_q  <= rend;
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.field_index   = idx_q;
  assign res_o.field_value   = val_q;
  assign res_o.present       = pres_q;
  assign res_o.status        = st_q;
  assign res_o.record_length = len_q;
  assign res_o.record_end    = end_q;

endmodule

`default_nettype wire

@@ hdl/srdd_checker.sv @@
// Port-level checks on the decoder's result stream, bound to the top level.
// Depends on srdd_pkg and sensor_record_delta_decoder_top.
`default_nettype none

module srdd_checker
  import srdd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        r_valid,
  input wire logic        r_ready,
  input wire logic [4:0]  r_idx,
  input wire logic [31:0] r_val,
  input wire logic        r_pres,
  input wire logic [1:0]  r_status,
  input wire logic [6:0]  r_len,
  input wire logic        r_end
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid && !r_ready |=> r_valid && $stable(r_idx) && $stable(r_val) && $stable(r_end))
    else $error("result beat changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid && r_status != ST_OK |-> r_end && r_idx == '0 && !r_pres && r_val == '0)
    else $error("error beat malformed");

  a_mid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid && !r_end |-> r_len == '0 && r_status == ST_OK)
    else $error("length or status on a non-final beat");

  a_epoch_pres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid && r_idx == '0 && r_status == ST_OK |-> r_pres)
    else $error("epoch beat not present");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid |-> r_idx <= 5'd18)
    else $error("field index out of range");

endmodule

bind sensor_record_delta_decoder_top srdd_checker u_srdd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .r_valid (result_o.valid),
  .r_ready (result_o.ready),
  .r_idx   (result_o.field_index),
  .r_val   (result_o.field_value),
  .r_pres  (result_o.present),
  .r_status(result_o.status),
  .r_len   (result_o.record_length),
  .r_end   (result_o.record_end)
);

`default_nettype wire

@@ verif/tb_srdd_chan_if.sv @@
// Testbench-side channel helpers: none needed beyond the RTL interfaces.
// This file holds the watchdog limit shared by the bench; depends on srdd_pkg.
`default_nettype none

package tb_srdd_pkg;
  import srdd_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned N_FIELDS   = 2 + SENSOR_SLOTS_DEF;
  localparam int unsigned ANCHOR_LEN = 4 + 2 * N_FIELDS;

  typedef struct packed {
    logic [4:0]  idx;
    logic [31:0] value;
    logic        pres;
    status_e     status;
    logic [6:0]  len;
    logic        rend;
  } field_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       anchor;
    logic       eob;
  } byte_beat_t;
endpackage

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking bench for sensor_record_delta_decoder_top: drives encoded records
// (directed table, then random anchor/delta records with noise) and checks each
// result beat against a behavioral decoder. Depends on srdd_pkg, tb_srdd_pkg, RTL.
`default_nettype none

module tb_top;
  import srdd_pkg::*;
  import tb_srdd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  srdd_in_if byte_if ();
  srdd_out_if res_if ();

  sensor_record_delta_decoder_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .byte_i(byte_if.sink), .result_o(res_if.source),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // decoder state
  logic [15:0] mcode;
  logic [31:0] last_ep, pend_ep, acc;
  logic [15:0] last_val [N_FIELDS];
  logic        val_ok [N_FIELDS];
  logic [15:0] pend_val [N_FIELDS];
  logic [17:0] pmask;
  int unsigned vcnt, cur_fld, rec_cnt;
  logic        is_anchor;

  field_beat_t expected_q[$];
  byte_beat_t  byte_q[$];
  int errors = 0, beats_seen = 0, idle_cycles = 0;
  int unsigned pushes = 0;
  bit idle_en = 1'b1, hold_off = 1'b0;

  task automatic push_beat(int idx, logic [31:0] v, logic p);
    field_beat_t e;
    e = '{idx[4:0], v, p, ST_OK, 7'd0, 1'b0};
    expected_q.push_back(e);
    pushes++;
  endtask

  task automatic close_rec(status_e st);
    field_beat_t e;
    e = expected_q.pop_back();
    e.status = st;
    e.len = rec_cnt[6:0];
    e.rend = 1'b1;
    expected_q.push_back(e);
  endtask

  task automatic clear_work();
    pmask = '0; acc = '0; vcnt = 0; cur_fld = 0; rec_cnt = 0; is_anchor = 1'b0;
  endtask

  task automatic decoder_reset();
    mcode = MISSING_RST; last_ep = '0; pend_ep = '0;
    for (int i = 0; i < N_FIELDS; i++) begin
      last_val[i] = '0; val_ok[i] = 1'b0; pend_val[i] = '0;
    end
    clear_work();
  endtask

  task automatic decode_byte(byte_beat_t bb);
    int unsigned pos, f;
    logic [31:0] u, d;
    logic [15:0] v;
    if (rec_cnt == 0) is_anchor = bb.anchor;
    rec_cnt = (rec_cnt + 1) & 7'h7f;
    if (is_anchor) begin
      pos = rec_cnt;
      if (pos <= 4) begin
        acc |= 32'(bb.data) << (8 * (pos - 1));
        if (pos == 4) begin
          pend_ep = acc; acc = '0;
          push_beat(0, pend_ep, 1'b1);
        end
      end else begin
        f = (pos - 5) >> 1;
        if (f >= N_FIELDS) f = N_FIELDS - 1;
        if (((pos - 5) & 1) == 0) acc = 32'(bb.data);
        else begin
          v = acc[15:0] | {bb.data, 8'h00};
          acc = '0;
          pend_val[f] = v;
          push_beat(f + 1, 32'(v), v != mcode);
          if (f == N_FIELDS - 1) begin
            last_ep = pend_ep;
            for (int i = 0; i < N_FIELDS; i++) begin
              last_val[i] = pend_val[i]; val_ok[i] = pend_val[i] != mcode;
            end
            close_rec(ST_OK); clear_work();
            return;
          end
        end
      end
    end else if (rec_cnt <= 3) begin
      pmask |= 18'(32'(bb.data) << (8 * (rec_cnt - 1)));
      if (rec_cnt == 3) begin
        cur_fld = 0; acc = '0; vcnt = 0;
      end
    end else begin
      acc |= 32'(bb.data[6:0]) << (7 * (vcnt & 7));
      vcnt++;
      if (bb.data[7]) begin
        if (vcnt >= 5) begin
          push_beat(0, '0, 1'b0); close_rec(ST_LONG); clear_work();
          return;
        end
      end else begin
        u = acc;
        d = (u >> 1) ^ (32'd0 - {31'd0, u[0]});
        acc = '0; vcnt = 0;
        if (cur_fld == 0) begin
          pend_ep = last_ep + d;
          push_beat(0, pend_ep, 1'b1);
        end else begin
          f = cur_fld - 1;
          if (f >= N_FIELDS) f = N_FIELDS - 1;
          v = val_ok[f] ? last_val[f] + d[15:0] : d[15:0];
          pend_val[f] = v;
          push_beat(f + 1, 32'(v), 1'b1);
        end
        cur_fld++;
        while (cur_fld <= N_FIELDS && !pmask[cur_fld - 1]) begin
          push_beat(cur_fld, 32'(mcode), 1'b0);
          cur_fld++;
        end
        if (cur_fld > N_FIELDS) begin
          last_ep = pend_ep;
          for (int i = 0; i < N_FIELDS; i++) begin
            if (pmask[i]) begin
              last_val[i] = pend_val[i]; val_ok[i] = 1'b1;
            end
          end
          close_rec(ST_OK); clear_work();
          return;
        end
      end
    end
    if (bb.eob) begin
      push_beat(0, '0, 1'b0); close_rec(ST_TRUNC); clear_work();
    end
  endtask

  // stimulus building
  task automatic put(logic [7:0] b, logic a = 1'b0, logic e = 1'b0);
    byte_q.push_back('{b, a, e});
  endtask

  task automatic put_varint(logic [31:0] val);
    logic [31:0] u;
    u = val;
    while (u > 32'h7f) begin
      put({1'b1, u[6:0]}); u = u >> 7;
    end
    put({1'b0, u[6:0]});
  endtask

  task automatic put_anchor(logic [31:0] ep, bit rnd_vals, logic [15:0] fixed);
    logic [15:0] v;
    put(ep[7:0], 1'b1); put(ep[15:8]); put(ep[23:16]); put(ep[31:24]);
    for (int i = 0; i < N_FIELDS; i++) begin
      v = rnd_vals ? ($urandom_range(0, 3) == 0 ? mcode : 16'($urandom)) : fixed;
      put(v[7:0]); put(v[15:8]);
    end
  endtask

  task automatic put_delta(logic [23:0] m);
    put(m[7:0], 1'b0); put(m[15:8]); put(m[23:16]);
    put_varint($urandom_range(0, 1) ? 32'($urandom_range(0, 300)) : $urandom);
    for (int i = 0; i < N_FIELDS; i++) begin
      if (m[i]) put_varint($urandom_range(0, 2) == 0 ? $urandom : 32'($urandom_range(0, 200)));
    end
  endtask

  // sender: one beat, valid left high after the accepting edge
  task automatic send_one(byte_beat_t bb);
    while (idle_en && $urandom_range(0, 99) < 31) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= bb.data;
    byte_if.anchor <= bb.anchor;
    byte_if.end_of_buffer <= bb.eob;
    do @(posedge clk_i); while (!byte_if.ready);
    decode_byte(bb);
  endtask

  task automatic send_all();
    while (byte_q.size() != 0) begin
      send_one(byte_q.pop_front());
    end
  endtask

  task automatic idle_in();
    byte_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_code(logic [15:0] c);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_data_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mcode = c;
  endtask

  // directed table: an all-ones anchor epoch cut by end of buffer, then an overlong varint and a truncated delta record
  typedef struct {
    logic [7:0] data; logic anchor; logic eob; bit chk; field_beat_t exp_beat;
  } dir_row_t;
  dir_row_t dir_tab[] = '{
    '{8'hff, 1'b1, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b1, 1'b1, '{5'd0, 32'd0, 1'b0, ST_TRUNC, 7'd4, 1'b1}},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, 1'b1, '{5'd0, 32'd0, 1'b0, ST_LONG, 7'd8, 1'b1}},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, 1'b1, '{5'd0, 32'd0, 1'b0, ST_TRUNC, 7'd2, 1'b1}}
  };

  task automatic run_directed();
    byte_beat_t bb;
    int unsigned n0;
    field_beat_t got;
    foreach (dir_tab[i]) begin
      bb = '{dir_tab[i].data, dir_tab[i].anchor, dir_tab[i].eob};
      n0 = pushes;
      send_one(bb);
      if (dir_tab[i].chk && pushes > n0) begin
        got = expected_q[$];
        if (got != dir_tab[i].exp_beat) begin
          errors++;
          if (errors <= 10) $display("table row %0d: expected %p predicted %p", i,
                                     dir_tab[i].exp_beat, got);
        end
      end
    end
    idle_in();
  endtask

  // result checker and sink idling
  initial begin
    field_beat_t e, g;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        g = '{res_if.field_index, res_if.field_value, res_if.present,
              status_e'(res_if.status), res_if.record_length, res_if.record_end};
        beats_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat %p", g);
        end else begin
          e = expected_q.pop_front();
          if (e != g) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", e, g);
          end
        end
      end
      res_if.ready <= !hold_off && !(idle_en && $urandom_range(0, 99) < 31);
    end
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else if (hold_off)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired");
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n_bytes;
    byte_if.valid = 1'b0; byte_if.data_byte = '0;
    byte_if.anchor = 1'b0; byte_if.end_of_buffer = 1'b0;
    decoder_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    drain();
    write_code(16'h7fff);
    put_anchor(32'h1234_5678, 1'b0, 16'h7fff);
    put_delta(24'hffffff);
    send_all();
    idle_in();
    drain();
    write_code(16'h0000);
    put_anchor($urandom, 1'b1, 16'h0);
    send_all();

    // long receiver stall with input pressure
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (5) put_delta(24'h000001);
        send_all();
        idle_in();
      end
    join
    drain();
    write_code(16'h8000);

    n_bytes = 0;
    while (n_bytes < 50) begin
      int unsigned sel;
      int unsigned start;
      start = byte_q.size();
      sel = $urandom_range(0, 99);
      if (n_bytes > 15) idle_en = 1'b0;
      if (n_bytes > 40) idle_en = 1'b1;
      if (sel < 15) put_anchor($urandom, 1'b1, 16'h0);
      else if (sel < 80) put_delta(24'($urandom));
      else if (sel < 90) begin
        put(8'($urandom), 1'b0); put(8'($urandom)); put(8'($urandom));
        repeat (5) put(8'h80 | 8'($urandom));
      end else begin
        put(8'($urandom), 1'($urandom)); put(8'($urandom));
        put(8'($urandom), 1'b0, 1'b1);
      end
      n_bytes += byte_q.size() - start;
      send_all();
    end
    idle_in();
    drain();
    write_code(16'($urandom));
    drain();
    put_delta(24'h3ffff);
    send_all();
    idle_in();
    drain();
    $display("covered %0d result beats: anchors, deltas, long varints, truncation, stalls",
             beats_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
